[hw/rtl/sparse_chunked_tile_store_macros.svh]
// Assertion macros for the tile store port checker
`ifndef SPARSE_CHUNKED_TILE_STORE_MACROS_SVH
`define SPARSE_CHUNKED_TILE_STORE_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define SCTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset
`define SCTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/scts_pkg.sv]
// Package of constants and types for the sparse chunked tile store
package scts_pkg;

	localparam int CHUNK_SIDE = 16;
	localparam int MAX_CHUNKS = 64;
	localparam int SIDE_BITS  = $clog2(CHUNK_SIDE);
	localparam int IDX_BITS   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CNT_BITS   = $clog2(MAX_CHUNKS + 1);
	localparam int CELL_BITS  = IDX_BITS + 2 * SIDE_BITS;
	localparam int CELL_DEPTH = MAX_CHUNKS * CHUNK_SIDE * CHUNK_SIDE;
	localparam int LIVE_BITS  = 9;
	localparam int CUSE_BITS  = 7;

	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_TOUCH = 3'd2,
		OP_QUERY = 3'd3,
		OP_ACK   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MATCH,
		ST_READ,
		ST_WRITE
	} fsm_t;

	typedef struct packed {
		logic        override_mark;
		logic [1:0]  quarter_turns;
		logic        flip_vertical;
		logic        flip_horizontal;
		logic [15:0] tile_id;
	} cell_t;

	typedef struct packed {
		logic [LIVE_BITS-1:0] live;
		logic                 dirty_inst;
		logic                 dirty_geom;
	} chunk_t;

endpackage

[hw/rtl/sparse_chunked_tile_store.sv]
// Top level of the sparse chunked tile store
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | op, cell_x/y, chunk_x/y, tile and variant bits
//  out     | output    | out_valid / out_stall| status, found, read cell, marks, counts
//
// Each transaction passes through capture, parallel tag compare over the
// chunk tag flops, memory read, then modify and write back into the cell and
// chunk memories. After reset a clearing pass over all CELL_DEPTH (16384) cell
// addresses empties both memories; input stalls during it, and also after each
// acceptance until write-back is done. A stalled result holds the write-back
// stage, so at most one transaction moves through the stages beside a held result.
module sparse_chunked_tile_store (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          op,
	input  logic signed [31:0]  cell_x,
	input  logic signed [31:0]  cell_y,
	input  logic signed [31:0]  chunk_x,
	input  logic signed [31:0]  chunk_y,
	input  logic [15:0]         tile_id,
	input  logic                flip_horizontal,
	input  logic                flip_vertical,
	input  logic [1:0]          quarter_turns,
	input  logic                override_mark,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                status,
	output logic                found,
	output logic [15:0]         read_tile,
	output logic                read_flip_horizontal,
	output logic                read_flip_vertical,
	output logic [1:0]          read_quarter_turns,
	output logic                read_override,
	output logic                dirty_geometry,
	output logic                dirty_instances,
	output logic [scts_pkg::LIVE_BITS-1:0] live_cells,
	output logic [scts_pkg::CUSE_BITS-1:0] chunks_in_use
);
	import scts_pkg::*;

	fsm_t state_q, state_d;
	logic [CELL_BITS-1:0] clr_q;

	// captured transaction
	op_t                  op_s1;
	logic signed [31:0]   kx_s1, ky_s1;
	logic [SIDE_BITS-1:0] lx_s1, ly_s1;
	cell_t                word_s1;

	logic [MAX_CHUNKS-1:0] hit_vec_s2, hit_vec_d;
	logic [IDX_BITS-1:0]   ch_s3;
	logic                  ch_ok_s3, status_s3;

	logic signed [31:0] tag_x_q [MAX_CHUNKS];
	logic signed [31:0] tag_y_q [MAX_CHUNKS];
	logic [CNT_BITS-1:0] count_q;

	cell_t  cell_mem [CELL_DEPTH];
	chunk_t chunk_mem [MAX_CHUNKS];
	cell_t  cell_rd_q;
	chunk_t chunk_rd_q;

	logic                 cell_we, chunk_we, mem_re;
	logic [CELL_BITS-1:0] cell_wa, cell_ra;
	logic [IDX_BITS-1:0]  chunk_wa, chunk_ra;
	cell_t                cell_wd;
	chunk_t               chunk_wd;

	logic                 accept, out_free, hit, alloc, ch_ok_d, status_d, op_ok, cell_op;
	logic [IDX_BITS-1:0]  enc, ch_sel;
	chunk_t               ent_new;
	logic                 found_d;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign cell_op  = (op == OP_WRITE) || (op == OP_READ);

	// compare the key against every allocated tag
	always_comb begin
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			hit_vec_d[i] = (tag_x_q[i] == kx_s1) && (tag_y_q[i] == ky_s1) &&
				(CNT_BITS'(i) < count_q);
		end
	end

	// encode the one-hot match and pick hit or fresh chunk
	always_comb begin
		enc = '0;
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			if (hit_vec_s2[i]) enc = enc | IDX_BITS'(i);
		end
		op_ok    = (op_s1 == OP_WRITE) || (op_s1 == OP_READ) || (op_s1 == OP_TOUCH) ||
			(op_s1 == OP_QUERY) || (op_s1 == OP_ACK);
		hit      = |hit_vec_s2;
		alloc    = (op_s1 == OP_WRITE) && !hit && (count_q < CNT_BITS'(MAX_CHUNKS));
		ch_sel   = hit ? enc : count_q[IDX_BITS-1:0];
		ch_ok_d  = op_ok && (hit || alloc);
		status_d = (op_s1 == OP_WRITE) && !hit && !alloc;
	end

	// modify the chunk entry and work out the result
	always_comb begin
		ent_new = chunk_rd_q;
		found_d = 1'b0;
		unique case (op_s1)
			OP_WRITE: begin
				if (cell_rd_q.tile_id == '0 && word_s1.tile_id != '0) begin
					ent_new.live = chunk_rd_q.live + LIVE_BITS'(1);
				end else if (cell_rd_q.tile_id != '0 && word_s1.tile_id == '0 &&
					chunk_rd_q.live != '0) begin
					ent_new.live = chunk_rd_q.live - LIVE_BITS'(1);
				end
				ent_new.dirty_geom = 1'b1;
				ent_new.dirty_inst = 1'b1;
			end
			OP_READ: begin
				found_d = ch_ok_s3 && (cell_rd_q.tile_id != '0);
			end
			OP_TOUCH: begin
				ent_new.dirty_inst = 1'b1;
				found_d = ch_ok_s3;
			end
			OP_QUERY: begin
				found_d = ch_ok_s3;
			end
			OP_ACK: begin
				ent_new.dirty_geom = 1'b0;
				ent_new.dirty_inst = 1'b0;
				found_d = ch_ok_s3;
			end
			default: begin
				found_d = 1'b0;
			end
		endcase
	end

	// next state, stall and memory port control
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		cell_we  = 1'b0;
		chunk_we = 1'b0;
		mem_re   = 1'b0;
		cell_wa  = clr_q;
		chunk_wa = clr_q[IDX_BITS-1:0];
		cell_wd  = '0;
		chunk_wd = '0;
		cell_ra  = {ch_sel, ly_s1, lx_s1};
		chunk_ra = ch_sel;
		unique case (state_q)
			ST_CLEAR: begin
				cell_we  = 1'b1;
				chunk_we = (clr_q < CELL_BITS'(MAX_CHUNKS));
				if (clr_q == CELL_BITS'(CELL_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = ST_MATCH;
			end
			ST_MATCH: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				mem_re  = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cell_wa  = {ch_s3, ly_s1, lx_s1};
				chunk_wa = ch_s3;
				cell_wd  = word_s1;
				chunk_wd = ent_new;
				if (out_free) begin
					cell_we  = ch_ok_s3 && (op_s1 == OP_WRITE);
					chunk_we = ch_ok_s3;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + CELL_BITS'(1);
		end
	end

	// capture the transaction and the pipeline of lookup results
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(op);
			kx_s1   <= cell_op ? (cell_x >>> SIDE_BITS) : chunk_x;
			ky_s1   <= cell_op ? (cell_y >>> SIDE_BITS) : chunk_y;
			lx_s1   <= cell_x[SIDE_BITS-1:0];
			ly_s1   <= cell_y[SIDE_BITS-1:0];
			word_s1 <= '{override_mark: override_mark, quarter_turns: quarter_turns,
				flip_vertical: flip_vertical, flip_horizontal: flip_horizontal,
				tile_id: tile_id};
		end
		if (state_q == ST_MATCH) hit_vec_s2 <= hit_vec_d;
		if (state_q == ST_READ) begin
			ch_s3     <= ch_sel;
			ch_ok_s3  <= ch_ok_d;
			status_s3 <= status_d;
		end
	end

	// allocate chunk tags
	always_ff @(posedge clk) begin
		if (state_q == ST_READ && alloc) begin
			tag_x_q[count_q[IDX_BITS-1:0]] <= kx_s1;
			tag_y_q[count_q[IDX_BITS-1:0]] <= ky_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ST_READ && alloc) begin
			count_q <= count_q + CNT_BITS'(1);
		end
	end

	// cell and chunk memories
	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		if (mem_re) cell_rd_q <= cell_mem[cell_ra];
	end

	always_ff @(posedge clk) begin
		if (chunk_we) chunk_mem[chunk_wa] <= chunk_wd;
		if (mem_re) chunk_rd_q <= chunk_mem[chunk_ra];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_WRITE && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && out_free) begin
			status               <= status_s3;
			found                <= found_d;
			read_tile            <= (op_s1 == OP_READ && found_d) ? cell_rd_q.tile_id : '0;
			read_flip_horizontal <= (op_s1 == OP_READ && found_d) && cell_rd_q.flip_horizontal;
			read_flip_vertical   <= (op_s1 == OP_READ && found_d) && cell_rd_q.flip_vertical;
			read_quarter_turns   <= (op_s1 == OP_READ && found_d) ? cell_rd_q.quarter_turns : '0;
			read_override        <= (op_s1 == OP_READ && found_d) && cell_rd_q.override_mark;
			dirty_geometry       <= ch_ok_s3 && ent_new.dirty_geom;
			dirty_instances      <= ch_ok_s3 && ent_new.dirty_inst;
			live_cells           <= ch_ok_s3 ? ent_new.live : '0;
			chunks_in_use        <= CUSE_BITS'(count_q);
		end
	end

endmodule

[hw/rtl/scts_checker.sv]
// Port-level checker for the tile store, bound to the top level
`include "sparse_chunked_tile_store_macros.svh"

module scts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic                status,
	input logic                found,
	input logic [15:0]         read_tile,
	input logic [scts_pkg::LIVE_BITS-1:0] live_cells,
	input logic [scts_pkg::CUSE_BITS-1:0] chunks_in_use
);
	import scts_pkg::*;

	// hold a stalled result
	`SCTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
	// a full table answers nothing else
	`SCTS_ASSERT_NOW(a_full_quiet, out_valid && status, !found && live_cells == '0, "full write not quiet")
	`SCTS_ASSERT_NOW(a_full_count, out_valid && status, chunks_in_use == CUSE_BITS'(MAX_CHUNKS), "full with free chunks")
	// a returned tile implies a hit
	`SCTS_ASSERT_NOW(a_tile_found, out_valid && read_tile != '0, found, "tile without hit")

endmodule

bind sparse_chunked_tile_store scts_checker u_scts_checker (.*);

[tb/sv/sparse_chunked_tile_store_checker.sv]
// Checker that predicts and compares every transaction of the tile store
`timescale 1ns / 1ps

module sparse_chunked_tile_store_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [2:0]          op,
	input  logic signed [31:0]  cell_x,
	input  logic signed [31:0]  cell_y,
	input  logic signed [31:0]  chunk_x,
	input  logic signed [31:0]  chunk_y,
	input  logic [15:0]         tile_id,
	input  logic                flip_horizontal,
	input  logic                flip_vertical,
	input  logic [1:0]          quarter_turns,
	input  logic                override_mark,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                status,
	input  logic                found,
	input  logic [15:0]         read_tile,
	input  logic                read_flip_horizontal,
	input  logic                read_flip_vertical,
	input  logic [1:0]          read_quarter_turns,
	input  logic                read_override,
	input  logic                dirty_geometry,
	input  logic                dirty_instances,
	input  logic [scts_pkg::LIVE_BITS-1:0] live_cells,
	input  logic [scts_pkg::CUSE_BITS-1:0] chunks_in_use,
	output int                  fail_count,
	output int                  pending
);
	import scts_pkg::*;

	localparam int CELLS = CHUNK_SIDE * CHUNK_SIDE;

	typedef struct packed {
		logic                 status;
		logic                 found;
		cell_t                word;
		logic                 geom;
		logic                 inst;
		logic [LIVE_BITS-1:0] live;
		logic [CUSE_BITS-1:0] used;
	} tile_result_t;

	logic signed [31:0] tag_x [MAX_CHUNKS];
	logic signed [31:0] tag_y [MAX_CHUNKS];
	int                 used_chunks;
	cell_t              grid [CELL_DEPTH];
	logic [8:0]         live_count [MAX_CHUNKS];
	logic [1:0]         marks [MAX_CHUNKS];   // bit 0 geometry, bit 1 instances
	tile_result_t       expected_results [$];

	function automatic int chunk_slot(logic signed [31:0] kx, logic signed [31:0] ky);
		for (int i = 0; i < used_chunks; i++)
			if (tag_x[i] == kx && tag_y[i] == ky)
				return i;
		return -1;
	endfunction

	// Apply one transaction to the shadow grid and work out its result
	function automatic tile_result_t predict_tile_op();
		tile_result_t r;
		int ch;
		int idx;
		cell_t w;
		r = '0;
		ch = -1;
		unique case (op)
			OP_WRITE: begin
				ch = chunk_slot(cell_x >>> SIDE_BITS, cell_y >>> SIDE_BITS);
				if (ch < 0) begin
					if (used_chunks < MAX_CHUNKS) begin
						ch = used_chunks;
						tag_x[ch] = cell_x >>> SIDE_BITS;
						tag_y[ch] = cell_y >>> SIDE_BITS;
						used_chunks++;
					end else
						r.status = 1'b1;
				end
				if (ch >= 0) begin
					idx = ch * CELLS + cell_y[SIDE_BITS-1:0] * CHUNK_SIDE + cell_x[SIDE_BITS-1:0];
					w = {override_mark, quarter_turns, flip_vertical, flip_horizontal, tile_id};
					if (grid[idx].tile_id == 0 && tile_id != 0)
						live_count[ch]++;
					else if (grid[idx].tile_id != 0 && tile_id == 0 && live_count[ch] > 0)
						live_count[ch]--;
					grid[idx] = w;
					marks[ch] = 2'b11;
				end
			end
			OP_READ: begin
				ch = chunk_slot(cell_x >>> SIDE_BITS, cell_y >>> SIDE_BITS);
				if (ch >= 0) begin
					idx = ch * CELLS + cell_y[SIDE_BITS-1:0] * CHUNK_SIDE + cell_x[SIDE_BITS-1:0];
					if (grid[idx].tile_id != 0) begin
						r.found = 1'b1;
						r.word = grid[idx];
					end
				end
			end
			OP_TOUCH, OP_QUERY, OP_ACK: begin
				ch = chunk_slot(chunk_x, chunk_y);
				if (ch >= 0) begin
					r.found = 1'b1;
					if (op == OP_TOUCH)
						marks[ch][1] = 1'b1;
					else if (op == OP_ACK)
						marks[ch] = 2'b00;
				end
			end
			default: ;
		endcase
		if (ch >= 0) begin
			r.geom = marks[ch][0];
			r.inst = marks[ch][1];
			r.live = live_count[ch];
		end
		r.used = used_chunks[CUSE_BITS-1:0];
		return r;
	endfunction

	// Count a mismatch, reporting only the first ten
	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v == act_v)
			return;
		if (fail_count < 10)
			$display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
		fail_count = fail_count + 1;
	endfunction

	// Compare results first, then record the transaction accepted at this edge
	always @(posedge clk or negedge arst_n) begin
		tile_result_t e;
		if (!arst_n) begin
			used_chunks = 0;
			fail_count = 0;
			expected_results.delete();
			pending = 0;
			for (int i = 0; i < MAX_CHUNKS; i++) begin
				live_count[i] = '0;
				marks[i] = '0;
			end
			for (int i = 0; i < CELL_DEPTH; i++)
				grid[i] = '0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("result with no transaction waiting");
					fail_count = fail_count + 1;
				end else begin
					e = expected_results.pop_front();
					check_field("status", e.status, status);
					check_field("found", e.found, found);
					check_field("read_tile", e.word.tile_id, read_tile);
					check_field("read_flip_horizontal", e.word.flip_horizontal,
						read_flip_horizontal);
					check_field("read_flip_vertical", e.word.flip_vertical,
						read_flip_vertical);
					check_field("read_quarter_turns", e.word.quarter_turns,
						read_quarter_turns);
					check_field("read_override", e.word.override_mark, read_override);
					check_field("dirty_geometry", e.geom, dirty_geometry);
					check_field("dirty_instances", e.inst, dirty_instances);
					check_field("live_cells", e.live, live_cells);
					check_field("chunks_in_use", e.used, chunks_in_use);
				end
			end
			if (in_valid && !in_stall)
				expected_results.insert(expected_results.size(), predict_tile_op());
			pending = expected_results.size();
		end
	end

endmodule

[tb/sv/sparse_chunked_tile_store_tb.sv]
// Stimulus, clocking and verdict for the sparse chunked tile store
`timescale 1ns / 1ps

module sparse_chunked_tile_store_tb;
	import scts_pkg::*;

	localparam logic [2:0] OP_SPARE_LO  = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL = 80;
	localparam logic signed [31:0] CHUNK_MIN = 32'shF8000000;
	localparam logic signed [31:0] CHUNK_MAX = 32'sh07FFFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] op;
	logic signed [31:0] cell_x, cell_y, chunk_x, chunk_y;
	logic [15:0] tile_id;
	logic flip_horizontal, flip_vertical, override_mark;
	logic [1:0] quarter_turns;
	logic status, found, read_flip_horizontal, read_flip_vertical, read_override;
	logic dirty_geometry, dirty_instances;
	logic [15:0] read_tile;
	logic [1:0] read_quarter_turns;
	logic [LIVE_BITS-1:0] live_cells;
	logic [CUSE_BITS-1:0] chunks_in_use;
	int fail_count, pending;
	int cycles = 0;
	logic calm;
	logic signed [31:0] pool_x [POOL];
	logic signed [31:0] pool_y [POOL];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sparse_chunked_tile_store dut (.*);
	sparse_chunked_tile_store_checker checker_i (.*);

	// End the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Hold off results for a random number of cycles per transaction
	initial begin
		int n;
		out_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 4);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	task automatic send_item(logic [2:0] o, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] kx, logic signed [31:0] ky, logic [15:0] t, logic [4:0] v);
		int gap;
		op <= o;
		cell_x <= x;
		cell_y <= y;
		chunk_x <= kx;
		chunk_y <= ky;
		tile_id <= t;
		{override_mark, quarter_turns, flip_vertical, flip_horizontal} <= v;
		in_valid <= 1'b1;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Cell address inside a chunk at a random local position
	function automatic logic signed [31:0] cell_in(logic signed [31:0] c);
		return (c <<< SIDE_BITS) | $urandom_range(0, CHUNK_SIDE - 1);
	endfunction

	initial begin
		int k, sel;
		logic [2:0] o;
		logic signed [31:0] x, y, kx, ky;
		in_valid <= 1'b0;
		op <= OP_WRITE;
		cell_x <= '0;
		cell_y <= '0;
		chunk_x <= '0;
		chunk_y <= '0;
		tile_id <= '0;
		{override_mark, quarter_turns, flip_vertical, flip_horizontal} <= '0;
		calm = 1'b0;
		pool_x[0] = CHUNK_MIN; pool_y[0] = CHUNK_MIN;
		pool_x[1] = CHUNK_MAX; pool_y[1] = CHUNK_MAX;
		pool_x[2] = -1;        pool_y[2] = 0;
		for (int i = 3; i < POOL; i++) begin
			pool_x[i] = $signed($urandom()) >>> SIDE_BITS;
			pool_y[i] = $signed($urandom()) >>> SIDE_BITS;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every op, absent chunks, clearing a cell, spare ops
		send_item(OP_READ, 32'sh80000000, 32'sh80000000, 0, 0, 16'h1, 5'h0);
		send_item(OP_QUERY, 0, 0, CHUNK_MIN, CHUNK_MIN, 0, 0);
		send_item(OP_WRITE, 32'sh80000000, 32'sh80000000, 0, 0, 16'hFFFF, 5'h1F);
		send_item(OP_WRITE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 16'h0001, 5'h15);
		send_item(OP_WRITE, -1, -1, 0, 0, 16'h8000, 5'h0A);
		send_item(OP_READ, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
		send_item(OP_READ, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0, 0);
		send_item(OP_READ, -1, -1, 0, 0, 0, 0);
		send_item(OP_READ, -2, -1, 0, 0, 0, 0);
		send_item(OP_QUERY, 0, 0, CHUNK_MIN, CHUNK_MIN, 0, 0);
		send_item(OP_ACK, 0, 0, CHUNK_MIN, CHUNK_MIN, 0, 0);
		send_item(OP_TOUCH, 0, 0, CHUNK_MIN, CHUNK_MIN, 0, 0);
		send_item(OP_QUERY, 0, 0, CHUNK_MIN, CHUNK_MIN, 0, 0);
		send_item(OP_TOUCH, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0);
		send_item(OP_ACK, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
		send_item(OP_WRITE, -1, -1, 0, 0, 16'h0000, 5'h1F);
		send_item(OP_WRITE, -1, -1, 0, 0, 16'h0000, 5'h00);
		send_item(OP_READ, -1, -1, 0, 0, 0, 0);
		send_item(OP_SPARE_LO, -1, -1, -1, 0, 16'hFFFF, 5'h1F);
		send_item(OP_SPARE_MID, 0, 0, CHUNK_MAX, CHUNK_MAX, 0, 0);
		send_item(OP_SPARE_HI, 0, 0, -1, 0, 0, 0);

		// Fill one chunk completely so the live count reaches its top
		for (int i = 0; i < CHUNK_SIDE * CHUNK_SIDE; i++) begin
			calm = (i >= 64 && i < 128);
			send_item(OP_WRITE, i % CHUNK_SIDE, i / CHUNK_SIDE, 0, 0,
				16'($urandom_range(1, 16'hFFFF)), 5'($urandom()));
		end
		calm = 1'b0;

		// Random mix over a pool of chunks larger than the table
		for (int i = 0; i < 600; i++) begin
			calm = (i >= 200 && i < 260);
			if (i == 300) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (pending != 0);
				@(posedge clk);
			end
			k = $urandom_range(0, POOL - 1);
			sel = $urandom_range(0, 99);
			o = sel < 45 ? OP_WRITE : sel < 75 ? OP_READ : sel < 82 ? OP_TOUCH :
				sel < 89 ? OP_QUERY : sel < 95 ? OP_ACK : 3'($urandom_range(5, 7));
			if ($urandom_range(0, 9) == 0) begin
				x = $urandom();
				y = $urandom();
			end else begin
				x = cell_in(pool_x[k]);
				y = cell_in(pool_y[k]);
			end
			if ($urandom_range(0, 6) == 0) begin
				kx = $urandom();
				ky = $urandom();
			end else begin
				kx = pool_x[k];
				ky = pool_y[k];
			end
			send_item(o, x, y, kx, ky,
				$urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom()), 5'($urandom()));
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/scts_pkg.sv
hw/rtl/sparse_chunked_tile_store.sv
hw/rtl/scts_checker.sv
tb/sv/sparse_chunked_tile_store_checker.sv
tb/sv/sparse_chunked_tile_store_tb.sv
